/* rtl/mhs_pkg.sv */
// Shared types, constants and aspect table for the MPEG-2 header scanner.
`timescale 1ns / 1ps
`default_nettype none
package mhs_pkg;

  localparam logic [23:0] START_PREFIX  = 24'h000001;
  localparam logic [23:0] WINDOW_RESET  = 24'hFFFFFF;
  localparam logic [7:0]  PICTURE_CODE  = 8'h00;
  localparam logic [7:0]  SEQUENCE_CODE = 8'hB3;

  localparam logic [3:0] ASPECT_SQUARE = 4'd1;
  localparam logic [3:0] ASPECT_4_3    = 4'd2;
  localparam logic [3:0] ASPECT_16_9   = 4'd3;
  localparam logic [3:0] ASPECT_221    = 4'd4;

  // Header fields of one finished buffer, before aspect scaling.
  typedef struct packed {
    logic [2:0]  picture_kind;
    logic        sequence_seen;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [3:0]  aspect_code;
  } mhs_result_t;

  function automatic logic [7:0] aspect_num(input logic [3:0] code);
    logic [7:0] n;
    case (code)
      ASPECT_SQUARE: n = 8'd1;
      ASPECT_4_3:    n = 8'd4;
      ASPECT_16_9:   n = 8'd16;
      ASPECT_221:    n = 8'd221;
      default:       n = 8'd0;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] aspect_den(input logic [3:0] code);
    logic [6:0] d;
    case (code)
      ASPECT_4_3:  d = 7'd3;
      ASPECT_16_9: d = 7'd9;
      ASPECT_221:  d = 7'd100;
      default:     d = 7'd1;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/mhs_scan.sv */
// Start code window, header capture state and per-buffer result register.
`timescale 1ns / 1ps
`default_nettype none
module mhs_scan
  import mhs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  input  wire logic        advance,
  output logic             res_valid,
  output mhs_result_t      res
);

  localparam logic [1:0] PIC_IDLE  = 2'd0;
  localparam logic [1:0] PIC_SKIP  = 2'd1;
  localparam logic [1:0] PIC_TYPE  = 2'd2;

  localparam logic [2:0] SEQ_IDLE  = 3'd0;
  localparam logic [2:0] SEQ_B1    = 3'd1;
  localparam logic [2:0] SEQ_B4    = 3'd4;

  logic [23:0] byte_window, byte_window_next;
  logic [1:0]  picture_phase, picture_phase_next;
  logic [2:0]  picture_kind_held, picture_kind_held_next;
  logic        picture_done, picture_done_next;
  logic [2:0]  sequence_phase, sequence_phase_next;
  logic [27:0] sequence_fields, sequence_fields_next;
  logic        sequence_done, sequence_done_next;
  logic        prefix;
  mhs_result_t res_next;

  assign prefix = (byte_window == START_PREFIX);

  always_comb begin
    picture_phase_next     = picture_phase;
    picture_kind_held_next = picture_kind_held;
    picture_done_next      = picture_done;
    unique case (picture_phase)
      PIC_SKIP: picture_phase_next = PIC_TYPE;
      PIC_TYPE: begin
        picture_kind_held_next = data_byte[5:3];
        picture_done_next      = 1'b1;
        picture_phase_next     = PIC_IDLE;
      end
      default: begin
        if (!picture_done && prefix && data_byte == PICTURE_CODE) begin
          picture_phase_next = PIC_SKIP;
        end
      end
    endcase

    sequence_phase_next  = sequence_phase;
    sequence_fields_next = sequence_fields;
    sequence_done_next   = sequence_done;
    if (sequence_phase >= SEQ_B1 && sequence_phase < SEQ_B4) begin
      sequence_fields_next = {sequence_fields[19:0], data_byte};
      sequence_phase_next  = sequence_phase + 3'd1;
    end else if (sequence_phase == SEQ_B4) begin
      sequence_fields_next = {sequence_fields[23:0], data_byte[7:4]};
      sequence_done_next   = 1'b1;
      sequence_phase_next  = SEQ_IDLE;
    end else if (!sequence_done && prefix && data_byte == SEQUENCE_CODE) begin
      sequence_phase_next  = SEQ_B1;
      sequence_fields_next = '0;
    end

    byte_window_next = {byte_window[15:0], data_byte};

    res_next.picture_kind  = picture_done_next ? picture_kind_held_next : 3'd0;
    res_next.sequence_seen = sequence_done_next;
    res_next.frame_width   = sequence_done_next ? sequence_fields_next[27:16] : 12'd0;
    res_next.frame_height  = sequence_done_next ? sequence_fields_next[15:4] : 12'd0;
    res_next.aspect_code   = sequence_done_next ? sequence_fields_next[3:0] : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window       <= WINDOW_RESET;
      picture_phase     <= PIC_IDLE;
      picture_kind_held <= 3'd0;
      picture_done      <= 1'b0;
      sequence_phase    <= SEQ_IDLE;
      sequence_fields   <= '0;
      sequence_done     <= 1'b0;
    end else if (accept) begin
      if (end_of_buffer) begin
        byte_window       <= WINDOW_RESET;
        picture_phase     <= PIC_IDLE;
        picture_kind_held <= 3'd0;
        picture_done      <= 1'b0;
        sequence_phase    <= SEQ_IDLE;
        sequence_fields   <= '0;
        sequence_done     <= 1'b0;
      end else begin
        byte_window       <= byte_window_next;
        picture_phase     <= picture_phase_next;
        picture_kind_held <= picture_kind_held_next;
        picture_done      <= picture_done_next;
        sequence_phase    <= sequence_phase_next;
        sequence_fields   <= sequence_fields_next;
        sequence_done     <= sequence_done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && end_of_buffer) begin
      res_valid <= 1'b1;
    end else if (advance) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_of_buffer) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/mhs_aspect.sv */
// Aspect table lookup, size scaling and output register.
`timescale 1ns / 1ps
`default_nettype none
module mhs_aspect
  import mhs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire mhs_result_t  res,
  input  wire logic         out_stall,
  output logic              out_valid,
  output logic [2:0]        picture_kind,
  output logic              sequence_seen,
  output logic [11:0]       frame_width,
  output logic [11:0]       frame_height,
  output logic [19:0]       aspect_numerator,
  output logic [18:0]       aspect_denominator
);

  logic [7:0]  num;
  logic [6:0]  den;
  logic [19:0] num_scaled;
  logic [18:0] den_scaled;

  assign num        = aspect_num(res.aspect_code);
  assign den        = aspect_den(res.aspect_code);
  // Widen the table factor first so the full product is kept.
  assign num_scaled = 20'(num) * 20'(res.frame_height);
  assign den_scaled = 19'(den) * 19'(res.frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      picture_kind       <= res.picture_kind;
      sequence_seen      <= res.sequence_seen;
      frame_width        <= res.frame_width;
      frame_height       <= res.frame_height;
      aspect_numerator   <= num_scaled;
      aspect_denominator <= den_scaled;
    end
  end

endmodule
`default_nettype wire

/* rtl/mpeg2_header_scanner_core.sv */
// Top level of the MPEG-2 picture and sequence header scanner.
// Path: the result word is latched into the result register when the byte
//   flagged as end of buffer is accepted, then moves on to the output register.
// Throughput: one byte word per cycle; the byte input stalls only while both the
//   result stage and the output register hold words and the output is stalled.
// Reset: synchronous, clears the start code window, capture state and both valids.
`timescale 1ns / 1ps
`default_nettype none
module mpeg2_header_scanner_core
  import mhs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       picture_kind,
  output logic             sequence_seen,
  output logic [11:0]      frame_width,
  output logic [11:0]      frame_height,
  output logic [19:0]      aspect_numerator,
  output logic [18:0]      aspect_denominator
);

  logic        accept;
  logic        res_valid;
  logic        advance;
  mhs_result_t res;

  // Move the pending result into the output register whenever that register
  // is empty or being drained this cycle.
  assign advance = res_valid && (!out_valid || !out_stall);

  // Hold the byte input only when the pending result cannot move on; bytes
  // that produce no result still flow while the output waits.
  assign in_stall = res_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Scanner: track the window, capture headers, latch the result on the
  // last byte of a buffer and clear for the next one.
  mhs_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .advance       (advance),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Aspect scaling: table lookup and two small products into the output word.
  mhs_aspect u_aspect (
    .clk                (clk),
    .rst                (rst),
    .load               (advance),
    .res                (res),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .picture_kind       (picture_kind),
    .sequence_seen      (sequence_seen),
    .frame_width        (frame_width),
    .frame_height       (frame_height),
    .aspect_numerator   (aspect_numerator),
    .aspect_denominator (aspect_denominator)
  );

endmodule
`default_nettype wire

/* test/mpeg2_header_scanner_core_tb.sv */
// Self-checking testbench for the MPEG-2 picture and sequence header scanner.
`timescale 1ns / 1ps
module mpeg2_header_scanner_core_tb;
  import mhs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 1500;
  localparam int SETTLE_CYCLES  = 20;

  // One buffer's summary as it should leave the block.
  typedef struct {
    logic [2:0]  kind;
    logic        seq_seen;
    logic [11:0] width;
    logic [11:0] height;
    logic [19:0] num;
    logic [18:0] den;
  } buffer_summary_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  picture_kind;
  logic        sequence_seen;
  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [19:0] aspect_numerator;
  logic [18:0] aspect_denominator;

  mpeg2_header_scanner_core dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .data_byte          (data_byte),
    .end_of_buffer      (end_of_buffer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .picture_kind       (picture_kind),
    .sequence_seen      (sequence_seen),
    .frame_width        (frame_width),
    .frame_height       (frame_height),
    .aspect_numerator   (aspect_numerator),
    .aspect_denominator (aspect_denominator)
  );

  always #5 clk = ~clk;

  // Scanner state as the testbench tracks it.
  logic [23:0] win;
  logic [1:0]  pic_phase;
  logic [2:0]  pic_kind;
  logic        pic_done;
  logic [2:0]  seq_phase;
  logic [27:0] seq_fields;
  logic        seq_done;

  buffer_summary_t pending_summaries[$];
  int  mismatches = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  function automatic void clear_scanner();
    win        = WINDOW_RESET;
    pic_phase  = 2'd0;
    pic_kind   = 3'd0;
    pic_done   = 1'b0;
    seq_phase  = 3'd0;
    seq_fields = 28'd0;
    seq_done   = 1'b0;
  endfunction

  function automatic int draw_wait(bit enable);
    return enable ? $urandom_range(0, 8) : 0;
  endfunction

  // Advance the tracked scanner by one accepted byte word; on the last byte,
  // queue the summary the block must return and clear for the next buffer.
  function automatic void scan_byte(logic [7:0] b, logic last);
    logic            prefix;
    logic [11:0]     w;
    logic [11:0]     h;
    logic [3:0]      a;
    int unsigned     n;
    int unsigned     d;
    buffer_summary_t s;
    prefix = (win == START_PREFIX);

    if (pic_phase == 2'd1) begin
      pic_phase = 2'd2;
    end else if (pic_phase == 2'd2) begin
      pic_kind  = b[5:3];
      pic_done  = 1'b1;
      pic_phase = 2'd0;
    end else if (!pic_done && prefix && b == PICTURE_CODE) begin
      pic_phase = 2'd1;
    end

    if (seq_phase >= 3'd1 && seq_phase <= 3'd3) begin
      seq_fields = {seq_fields[19:0], b};
      seq_phase  = seq_phase + 3'd1;
    end else if (seq_phase == 3'd4) begin
      seq_fields = {seq_fields[23:0], b[7:4]};
      seq_done   = 1'b1;
      seq_phase  = 3'd0;
    end else if (!seq_done && prefix && b == SEQUENCE_CODE) begin
      seq_phase  = 3'd1;
      seq_fields = 28'd0;
    end

    win = {win[15:0], b};
    if (!last) return;

    s.kind = pic_done ? pic_kind : 3'd0;
    s.seq_seen = seq_done;
    s.width = 12'd0;
    s.height = 12'd0;
    s.num = 20'd0;
    s.den = 19'd0;
    if (seq_done) begin
      w = seq_fields[27:16];
      h = seq_fields[15:4];
      a = seq_fields[3:0];
      // Pixel aspect ratio table; unlisted codes read as 0/1.
      case (a)
        ASPECT_SQUARE: begin n = 1;   d = 1;   end
        ASPECT_4_3:    begin n = 4;   d = 3;   end
        ASPECT_16_9:   begin n = 16;  d = 9;   end
        ASPECT_221:    begin n = 221; d = 100; end
        default:       begin n = 0;   d = 1;   end
      endcase
      s.width  = w;
      s.height = h;
      s.num    = 20'(n * h);
      s.den    = 19'(d * w);
    end
    pending_summaries.push_back(s);
    clear_scanner();
  endfunction

  // Offer one byte word after a random gap and hold it until accepted.
  // Valid stays high after acceptance so back-to-back words need one update.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = draw_wait(sender_idles);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_buffer <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(b, last);
  endtask

  // Drop valid and hold off until every queued summary has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_summaries.size() != 0) @(posedge clk);
  endtask

  task automatic send_buffer(ref logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Take each result word, compare it with the oldest expectation, then
  // draw the next receiver stall.
  always @(posedge clk) begin
    buffer_summary_t s;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (pending_summaries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected", $time);
      end else begin
        s = pending_summaries.pop_front();
        check_field("picture_kind", s.kind, picture_kind);
        check_field("sequence_seen", s.seq_seen, sequence_seen);
        check_field("frame_width", s.width, frame_width);
        check_field("frame_height", s.height, frame_height);
        check_field("aspect_numerator", s.num, aspect_numerator);
        check_field("aspect_denominator", s.den, aspect_denominator);
      end
      stall_left = draw_wait(receiver_idles);
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // End the run when neither side moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hand-picked buffers: full picture and sequence headers with extreme
  // sizes, a lone last byte, a sequence header cut off by the buffer end,
  // and a start code split across two buffers.
  task automatic test_directed_headers();
    logic [7:0] bytes[$];
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    bytes = '{8'h00, 8'h00, 8'h01, PICTURE_CODE, 8'h00, 8'h18,
              8'h00, 8'h00, 8'h01, SEQUENCE_CODE, 8'hFF, 8'hFF, 8'hFF, 8'h4F};
    send_buffer(bytes);
    bytes = '{8'h5A};
    send_buffer(bytes);
    bytes = '{8'h00, 8'h00, 8'h01, SEQUENCE_CODE, 8'h00, 8'h00, 8'h00};
    send_buffer(bytes);
    // Start of this buffer would complete a picture code only across buffers.
    bytes = '{8'h01, PICTURE_CODE, 8'h00, 8'h38};
    send_buffer(bytes);
    wait_drained();
  endtask

  // Build one buffer from headers, partial prefixes and noise; sometimes cut
  // it short so a header is left unfinished.
  task automatic build_buffer(ref logic [7:0] bytes[$]);
    int          segs;
    logic [11:0] w;
    logic [11:0] h;
    logic [3:0]  a;
    bytes.delete();
    segs = $urandom_range(1, 5);
    repeat (segs) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          bytes.push_back(8'h00); bytes.push_back(8'h00); bytes.push_back(8'h01);
          bytes.push_back(PICTURE_CODE);
          bytes.push_back(8'($urandom_range(0, 255)));
          bytes.push_back(8'($urandom_range(0, 255)));
        end
        3, 4, 5: begin
          w = 12'($urandom_range(0, 4095));
          h = 12'($urandom_range(0, 4095));
          if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          if ($urandom_range(0, 7) == 0) h = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          a = $urandom_range(0, 1) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(0, 15));
          bytes.push_back(8'h00); bytes.push_back(8'h00); bytes.push_back(8'h01);
          bytes.push_back(SEQUENCE_CODE);
          bytes.push_back(w[11:4]);
          bytes.push_back({w[3:0], h[11:8]});
          bytes.push_back(h[7:0]);
          bytes.push_back({a, 4'($urandom_range(0, 15))});
        end
        6: begin
          bytes.push_back(8'h00); bytes.push_back(8'h00); bytes.push_back(8'h01);
          bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
              0:       bytes.push_back(8'h00);
              1:       bytes.push_back(8'h01);
              2:       bytes.push_back(SEQUENCE_CODE);
              default: bytes.push_back(8'($urandom_range(0, 255)));
            endcase
          end
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0)
      bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
  endtask

  // Full-rate stream: no gaps from the sender, no stalls from the receiver.
  task automatic test_back_to_back();
    logic [7:0] bytes[$];
    int sent;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    sent = 0;
    while (sent < 200) begin
      build_buffer(bytes);
      send_buffer(bytes);
      sent += bytes.size();
    end
    wait_drained();
  endtask

  // Bulk random buffers; switch idling on and off in stretches and pause
  // now and then until the block is empty.
  task automatic test_random_buffers();
    logic [7:0] bytes[$];
    int sent;
    int buffers;
    sent = 0;
    buffers = 0;
    while (sent < RANDOM_BYTES) begin
      if (buffers % 8 == 0) begin
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
      end
      build_buffer(bytes);
      send_buffer(bytes);
      sent += bytes.size();
      buffers++;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    clear_scanner();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_headers();
    test_back_to_back();
    test_random_buffers();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_summaries.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
